@@ hw/rtl/rvc_cmp_pkg.sv @@
// Shared types and encoding constants for the RV32I to RVC compressor.
// Used by rvc_cmp_decode and rv32i_to_rvc_compressor_core; depends on nothing.
`default_nettype none

package rvc_cmp_pkg;

    localparam int unsigned INSTR_W  = 32;
    localparam int unsigned OFFSET_W = 21;
    localparam int unsigned S_DATA_W = 56;
    localparam int unsigned M_DATA_W = 32;

    // Major opcodes handled by the compressor.
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_OP_IMM = 7'h13;
    localparam logic [6:0] OPC_JAL    = 7'h6f;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_BRANCH = 7'h63;

    // funct3 codes.
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_WORD = 3'd2;
    localparam logic [2:0] F3_RSV3 = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;

    // funct7 codes.
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    // RVC funct2 codes for the CA and CB arithmetic groups.
    localparam logic [1:0] FN2_SUB_SRLI = 2'd0;
    localparam logic [1:0] FN2_XOR_SRAI = 2'd1;
    localparam logic [1:0] FN2_OR_ANDI  = 2'd2;
    localparam logic [1:0] FN2_AND      = 2'd3;

    typedef struct packed {
        logic [INSTR_W-1:0] result_word;
        logic               is_compressed;
    } rvc_result_t;

endpackage

`default_nettype wire

@@ hw/rtl/rvc_cmp_decode.sv @@
// Combinational decode and re-encode of one RV32I word into RVC form.
// Depends on rvc_cmp_pkg for opcodes, codes and the result struct.
`default_nettype none

module rvc_cmp_decode
    import rvc_cmp_pkg::*;
(
    input  wire logic [INSTR_W-1:0]  instr_word,
    input  wire logic [OFFSET_W-1:0] rel_offset,
    output rvc_result_t              result
);

    logic [6:0]  op;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [6:0]  f7;
    logic        imm_fits6;
    logic        imm_zero;
    logic        rd_creg;
    logic        rs1_creg;
    logic        rs2_creg;
    logic [1:0]  fn2;
    logic        fn2_ok;
    logic [15:0] c;
    logic [31:0] br_rewrite;

    assign op  = instr_word[6:0];
    assign rd  = instr_word[11:7];
    assign f3  = instr_word[14:12];
    assign rs1 = instr_word[19:15];
    assign rs2 = instr_word[24:20];
    assign f7  = instr_word[31:25];

    // A 12-bit immediate lies in -32..31 when its top seven bits are all copies of bit 5.
    assign imm_fits6 = (instr_word[31:25] == {7{instr_word[25]}});
    assign imm_zero  = (instr_word[31:20] == 12'd0);
    assign rd_creg   = (rd[4:3] == 2'b01);
    assign rs1_creg  = (rs1[4:3] == 2'b01);
    assign rs2_creg  = (rs2[4:3] == 2'b01);

    // The relocated offset replaces the B-type offset fields of a long branch.
    assign br_rewrite = {rel_offset[20], rel_offset[9:4], instr_word[24:12],
                         rel_offset[3:0], rel_offset[10], instr_word[6:0]};

    always_comb begin
        fn2    = FN2_SUB_SRLI;
        fn2_ok = 1'b0;
        c      = 16'd0;
        result.result_word   = instr_word;
        result.is_compressed = 1'b0;
        case (op)
            OPC_OP: begin
                case (f3)
                    F3_ADD: begin fn2 = FN2_SUB_SRLI; fn2_ok = 1'b1; end
                    F3_XOR: begin fn2 = FN2_XOR_SRAI; fn2_ok = 1'b1; end
                    F3_OR:  begin fn2 = FN2_OR_ANDI;  fn2_ok = 1'b1; end
                    F3_AND: begin fn2 = FN2_AND;      fn2_ok = 1'b1; end
                    default: begin fn2 = FN2_SUB_SRLI; fn2_ok = 1'b0; end
                endcase
                if (f3 == F3_ADD && f7 == F7_BASE) begin
                    if (rd != 5'd0 && rs2 != 5'd0 && (rd == rs1 || rs1 == 5'd0)) begin
                        c = {3'b100, (rs1 != 5'd0), rd, rs2, 2'b10};
                        result.result_word   = {16'd0, c};
                        result.is_compressed = 1'b1;
                    end
                end else if (f7 == F7_BASE || (f3 == F3_ADD && f7 == F7_ALT)) begin
                    if (fn2_ok && rd == rs1 && rd_creg && rs2_creg) begin
                        c = {6'b100011, rs1[2:0], fn2, rs2[2:0], 2'b01};
                        result.result_word   = {16'd0, c};
                        result.is_compressed = 1'b1;
                    end
                end
            end
            OPC_LUI: begin
                if (rd != 5'd0 && rd != 5'd2 &&
                    instr_word[31:17] == {15{instr_word[17]}} &&
                    instr_word[31:12] != 20'd0) begin
                    c = {3'b011, instr_word[31], rd, instr_word[16:12], 2'b01};
                    result.result_word   = {16'd0, c};
                    result.is_compressed = 1'b1;
                end
            end
            OPC_OP_IMM: begin
                if (f3 == F3_ADD) begin
                    if (rs1 == 5'd0 && rd != 5'd0 && imm_fits6) begin
                        c = {3'b010, instr_word[31], rd, instr_word[24:20], 2'b01};
                        result.result_word   = {16'd0, c};
                        result.is_compressed = 1'b1;
                    end else if (rd == rs1 && rd != 5'd0 && !imm_zero && imm_fits6) begin
                        c = {3'b000, instr_word[31], rd, instr_word[24:20], 2'b01};
                        result.result_word   = {16'd0, c};
                        result.is_compressed = 1'b1;
                    end
                end else if (f3 == F3_SLL) begin
                    if (f7 == F7_BASE && rd == rs1 && rd != 5'd0) begin
                        c = {4'b0000, rd, instr_word[24:20], 2'b10};
                        result.result_word   = {16'd0, c};
                        result.is_compressed = 1'b1;
                    end
                end else if (f3 inside {F3_SR, F3_AND}) begin
                    if (f3 == F3_AND) begin
                        fn2    = FN2_OR_ANDI;
                        fn2_ok = imm_fits6;
                    end else if (f7 == F7_BASE) begin
                        fn2    = FN2_SUB_SRLI;
                        fn2_ok = 1'b1;
                    end else if (f7 == F7_ALT) begin
                        fn2    = FN2_XOR_SRAI;
                        fn2_ok = 1'b1;
                    end else begin
                        fn2    = FN2_SUB_SRLI;
                        fn2_ok = 1'b0;
                    end
                    if (fn2_ok && rd == rs1 && rd_creg) begin
                        c = {3'b100, (f3 == F3_AND) & instr_word[31], fn2, rd[2:0],
                             instr_word[24:20], 2'b01};
                        result.result_word   = {16'd0, c};
                        result.is_compressed = 1'b1;
                    end
                end
            end
            OPC_JALR: begin
                if ((rd == 5'd0 || rd == 5'd1) && rs1 != 5'd0 && imm_zero) begin
                    c = {3'b100, (rd == 5'd1), rs1, 5'd0, 2'b10};
                    result.result_word   = {16'd0, c};
                    result.is_compressed = 1'b1;
                end
            end
            OPC_LOAD: begin
                // Offset 0..124 and word aligned: bits 11:7 and 1:0 of the immediate are zero.
                if (f3 == F3_WORD && rd_creg && rs1_creg &&
                    instr_word[31:27] == 5'd0 && instr_word[21:20] == 2'd0) begin
                    c = {3'b010, instr_word[25], instr_word[24], instr_word[23], rs1[2:0],
                         instr_word[22], instr_word[26], rd[2:0], 2'b00};
                    result.result_word   = {16'd0, c};
                    result.is_compressed = 1'b1;
                end
            end
            OPC_STORE: begin
                if (f3 == F3_WORD && rs1_creg && rs2_creg &&
                    instr_word[31:27] == 5'd0 && instr_word[8:7] == 2'd0) begin
                    c = {3'b110, instr_word[25], instr_word[11], instr_word[10], rs1[2:0],
                         instr_word[9], instr_word[26], rs2[2:0], 2'b00};
                    result.result_word   = {16'd0, c};
                    result.is_compressed = 1'b1;
                end
            end
            OPC_BRANCH: begin
                if (f3 == F3_WORD || f3 == F3_RSV3) begin
                    result.result_word = instr_word;
                end else if ((f3 == F3_BEQ || f3 == F3_BNE) && rs1_creg && rs2 == 5'd0) begin
                    c = {2'b11, (f3 == F3_BNE), rel_offset[20], rel_offset[3], rel_offset[2],
                         rs1[2:0], rel_offset[6], rel_offset[5], rel_offset[1],
                         rel_offset[0], rel_offset[4], 2'b01};
                    result.result_word   = {16'd0, c};
                    result.is_compressed = 1'b1;
                end else begin
                    result.result_word = br_rewrite;
                end
            end
            OPC_JAL: begin
                if (rd == 5'd0 || rd == 5'd1) begin
                    c = {(rd == 5'd0), 2'b01, rel_offset[20], rel_offset[3], rel_offset[8],
                         rel_offset[7], rel_offset[9], rel_offset[5], rel_offset[6],
                         rel_offset[2], rel_offset[1], rel_offset[0], rel_offset[4], 2'b01};
                    result.result_word   = {16'd0, c};
                    result.is_compressed = 1'b1;
                end
            end
            default: begin
                result.result_word   = instr_word;
                result.is_compressed = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/rv32i_to_rvc_compressor_core.sv @@
// Top level of the RV32I to RVC compressor: input register, decode, result register.
// Depends on rvc_cmp_pkg and rvc_cmp_decode.
// The accepted item is registered in stage one, then decoded and registered in stage two,
// whose valid flag drives m_tvalid.
// Throughput is one item per cycle; the pipeline only stalls when m_tready is held low.
// Reset (aresetn low, synchronous) empties both pipeline stages; payload is not cleared.
`default_nettype none

module rv32i_to_rvc_compressor_core
    import rvc_cmp_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // Input item stream.
    input  wire logic                s_tvalid,
    output      logic                s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,   // [31:0] instr_word, [52:32] rel_offset, zero pad
    // Result item stream.
    output      logic                m_tvalid,
    input  wire logic                m_tready,
    output      logic [M_DATA_W-1:0] m_tdata,   // [31:0] result_word
    output      logic                m_tuser    // [0] is_compressed
);

    // Stage one holds the accepted item; stage two holds the finished result.
    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic [INSTR_W-1:0]  s1_instr_reg;
    logic [OFFSET_W-1:0] s1_offset_reg;
    logic                s2_valid_reg;
    logic                s2_valid_next;
    rvc_result_t         s2_result_reg;
    rvc_result_t         dec_result;
    logic                s1_free;
    logic                s2_free;

    // Each stage may take a new item when it is empty or when its contents move on
    // in the same cycle, so a full pipeline still accepts one item per cycle while m_tready is high.
    assign s2_free  = !s2_valid_reg || m_tready;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign s_tready = s1_free;

    assign s1_valid_next = s1_free ? s_tvalid : s1_valid_reg;
    assign s2_valid_next = s2_free ? s1_valid_reg : s2_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Payload registers load only when an item actually moves into the stage.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s1_free) begin
            s1_instr_reg  <= s_tdata[INSTR_W-1:0];
            s1_offset_reg <= s_tdata[INSTR_W+OFFSET_W-1:INSTR_W];
        end
        if (s1_valid_reg && s2_free) begin
            s2_result_reg <= dec_result;
        end
    end

    // All of the compression work sits between the two stages.
    rvc_cmp_decode u_decode (
        .instr_word (s1_instr_reg),
        .rel_offset (s1_offset_reg),
        .result     (dec_result)
    );

    assign m_tvalid = s2_valid_reg;
    assign m_tdata  = s2_result_reg.result_word;
    assign m_tuser  = s2_result_reg.is_compressed;

    // An item leaving stage one must arrive in stage two with its decoded result.
    a_s1_to_s2: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && s2_free |=> s2_valid_reg && s2_result_reg == $past(dec_result))
        else $error("decoded result not captured in result stage");

    // A compressed result never carries anything in the upper halfword.
    a_upper_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_valid_reg && s2_result_reg.is_compressed |-> s2_result_reg.result_word[31:16] == 16'd0)
        else $error("compressed result has nonzero upper halfword");

    // A blocked stage one keeps its item untouched.
    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s2_free |=> s1_valid_reg && $stable(s1_instr_reg)
            && $stable(s1_offset_reg))
        else $error("stage one item lost while blocked");

    // Input backpressure only appears when both stages are occupied.
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> s1_valid_reg && s2_valid_reg && !m_tready)
        else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire
